>>> rtl/vsht_pkg.sv
// Package: types and constants for the visited-state hash table.
package vsht_pkg;
    localparam int KEY_ELEMENTS_D = 9;
    localparam int ELEMENT_BITS_D = 4;
    localparam int BUCKETS_D      = 1024;
    localparam int WAYS_D         = 4;

    localparam int KEY_W   = 36;
    localparam int COST_W  = 7;
    localparam int ENTRY_W = 13;
    localparam int COLL_W  = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] ST_NEW      = 2'd0;
    localparam logic [1:0] ST_PRESENT  = 2'd1;
    localparam logic [1:0] ST_IMPROVED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [KEY_W-1:0]  state_key;
        logic [COST_W-1:0] path_cost;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [COST_W-1:0]  stored_cost;
        logic               settled;
        logic [ENTRY_W-1:0] entry_count;
        logic [COLL_W-1:0]  collision_count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_READ, S_WAIT, S_UPDATE
    } t_state;
endpackage

>>> rtl/vsht_hash.sv
// Sequential polynomial hash: one tile per cycle, result modulo BUCKETS.
module vsht_hash #(
    parameter int KEY_ELEMENTS = vsht_pkg::KEY_ELEMENTS_D,
    parameter int ELEMENT_BITS = vsht_pkg::ELEMENT_BITS_D,
    parameter int BUCKETS      = vsht_pkg::BUCKETS_D,
    parameter int BKT_W        = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [vsht_pkg::KEY_W-1:0] i_key,
    output logic                      o_done,
    output logic [BKT_W-1:0]          o_bucket
);
    import vsht_pkg::*;
    localparam int CNT_W = $clog2(KEY_ELEMENTS + 3);
    localparam int WIDE  = KEY_ELEMENTS * ELEMENT_BITS + KEY_W;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));
    localparam logic [31:0] BKT32 = 32'(BUCKETS);
    localparam logic [CNT_W-1:0] CNT_HASHED = CNT_W'(KEY_ELEMENTS);
    localparam logic [CNT_W-1:0] CNT_QUOT   = CNT_W'(KEY_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_DONE   = CNT_W'(KEY_ELEMENTS + 2);

    logic [WIDE-1:0]        r_key;
    logic [31:0]            r_hash;
    logic [31:0]            r_quot;
    logic [31:0]            r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_run;
    logic [ELEMENT_BITS-1:0] tile;
    logic [31:0]            n_hash;
    logic [63:0]            prod;
    logic [31:0]            rem_fix;

    assign tile   = r_key[KEY_ELEMENTS*ELEMENT_BITS-1 -: ELEMENT_BITS];
    assign n_hash = (r_hash << 5) - r_hash + 32'(tile) + 32'd48;

    // Quotient estimate is low by at most one, so one compare-subtract finishes.
    assign prod    = 64'(r_hash) * 64'(RECIP);
    assign rem_fix = (r_rem >= BKT32) ? (r_rem - BKT32) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_load) begin
            r_run <= 1'b1;
            r_cnt <= '0;
        end else if (o_done) begin
            r_run <= 1'b0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_load) begin
            r_key  <= WIDE'(i_key);
            r_hash <= '0;
        end else if (r_run && r_cnt < CNT_HASHED) begin
            r_key  <= r_key << ELEMENT_BITS;
            r_hash <= n_hash;
        end
        if (r_run && r_cnt == CNT_HASHED) r_quot <= prod[63:32];
        if (r_run && r_cnt == CNT_QUOT) r_rem <= r_hash - r_quot * BKT32;
    end

    assign o_done   = r_run && r_cnt == CNT_DONE;
    assign o_bucket = BKT_W'(rem_fix);
endmodule

>>> rtl/visited_state_hash_table.sv
// Top level: visited-state hash table with one bucket row per memory word.
// An item is taken when start is high and busy is low, and busy then stays high
// while the hash walks one tile per cycle, a registered quotient by reciprocal
// multiply and a registered remainder reduce it modulo BUCKETS, the bucket is
// registered, and then come the row read of the bucket memory, the way compare
// and the write-back. The result strobes for one cycle as busy falls and cannot be
// stalled, so the table takes no new item until it is through with the last one.
// After reset a clearing pass writes every bucket row empty with busy high.
module visited_state_hash_table #(
    parameter int KEY_ELEMENTS = vsht_pkg::KEY_ELEMENTS_D,
    parameter int ELEMENT_BITS = vsht_pkg::ELEMENT_BITS_D,
    parameter int BUCKETS      = vsht_pkg::BUCKETS_D,
    parameter int WAYS         = vsht_pkg::WAYS_D
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  vsht_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output vsht_pkg::t_out_item o_item
);
    import vsht_pkg::*;
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int KB     = KEY_ELEMENTS * ELEMENT_BITS;
    localparam int KM_W   = (KB < KEY_W) ? KB : KEY_W;
    localparam int SLOT_W = 1 + KM_W + COST_W;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef struct packed {
        logic              valid;
        logic [KM_W-1:0]   key;
        logic [COST_W-1:0] cost;
    } t_slot;

    t_slot r_mem [BUCKETS][WAYS];
    t_slot r_row [WAYS];
    t_slot n_row [WAYS];

    t_state             r_state, n_state;
    logic [BKT_W-1:0]   r_clr;
    logic [BKT_W-1:0]   r_bkt;
    t_in_item           r_in;
    logic [ENTRY_W-1:0] r_entries, n_entries;
    logic [COLL_W-1:0]  r_coll, n_coll;
    t_out_item          r_out, n_out;
    logic               r_strobe;
    logic               hash_load, hash_done, we, accept;
    logic [BKT_W-1:0]   hash_bkt, wr_addr;
    logic [KM_W-1:0]    key_m;

    assign accept  = start && !busy;
    assign key_m   = r_in.state_key[KM_W-1:0];
    assign hash_load = accept;

    vsht_hash #(.KEY_ELEMENTS(KEY_ELEMENTS), .ELEMENT_BITS(ELEMENT_BITS),
        .BUCKETS(BUCKETS), .BKT_W(BKT_W)) u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(hash_load), .i_key(i_item.state_key),
        .o_done(hash_done), .o_bucket(hash_bkt));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == BKT_W'(BUCKETS - 1)) n_state = S_IDLE;
            S_IDLE:   if (start) n_state = S_HASH;
            S_HASH:   if (hash_done) n_state = S_READ;
            S_READ:   n_state = S_WAIT;
            S_WAIT:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        logic hit_f, free_f;
        logic [WAY_W-1:0] hit_w, free_w;
        hit_f = 1'b0; free_f = 1'b0; hit_w = '0; free_w = '0;
        for (int w = 0; w < WAYS; w++) begin
            n_row[w] = r_row[w];
            if (r_row[w].valid) begin
                if (!hit_f && r_row[w].key == key_m) begin
                    hit_f = 1'b1; hit_w = WAY_W'(w);
                end
            end else if (!free_f) begin
                free_f = 1'b1; free_w = WAY_W'(w);
            end
        end
        n_entries = r_entries;
        n_coll    = r_coll;
        n_out     = '0;
        we        = 1'b0;
        if (r_in.opcode == OP_INSERT) begin
            if (hit_f) begin
                n_out.found = 1'b1;
                if (r_in.path_cost < r_row[hit_w].cost) begin
                    n_row[hit_w].cost = r_in.path_cost;
                    n_out.status = ST_IMPROVED;
                    we = 1'b1;
                end else begin
                    n_out.status = ST_PRESENT;
                end
                n_out.stored_cost = n_row[hit_w].cost;
            end else if (!free_f) begin
                n_out.status = ST_FULL;
            end else begin
                n_row[free_w].valid = 1'b1;
                n_row[free_w].key   = key_m;
                n_row[free_w].cost  = r_in.path_cost;
                we = 1'b1;
                n_out.status = ST_NEW;
                if (r_entries != '1) n_entries = r_entries + 1'b1;
                if (r_row[0].valid && r_coll != '1) n_coll = r_coll + 1'b1;
            end
        end else if (hit_f) begin
            n_out.found       = 1'b1;
            n_out.stored_cost = r_row[hit_w].cost;
            n_out.settled     = r_in.path_cost >= r_row[hit_w].cost;
        end
        n_out.entry_count     = n_entries;
        n_out.collision_count = n_coll;
        if (r_state != S_UPDATE) we = 1'b0;
        if (r_state == S_CLEAR) we = 1'b1;
    end

    assign wr_addr = (r_state == S_CLEAR) ? r_clr : r_bkt;

    always_ff @(posedge i_clk) begin
        if (we) begin
            for (int w = 0; w < WAYS; w++)
                r_mem[wr_addr][w] <= (r_state == S_CLEAR) ? t_slot'('0) : n_row[w];
        end
        if (r_state == S_READ) begin
            for (int w = 0; w < WAYS; w++) r_row[w] <= r_mem[r_bkt][w];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_entries <= '0;
            r_coll    <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_UPDATE);
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == S_UPDATE) begin
                r_entries <= n_entries;
                r_coll    <= n_coll;
            end
        end
        if (accept) r_in <= i_item;
        if (hash_done) r_bkt <= hash_bkt;
        if (r_state == S_UPDATE) r_out <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_item   = r_out;
endmodule
